// ===== hw/rtl/hcr_pkg.sv =====
// shared constants, types and register codes for the height to color ramp
// no dependencies
package hcr_pkg;

    localparam int NUM_COLORS = 5;
    localparam int PAL_N      = 5;
    localparam int SEG_W      = $clog2(NUM_COLORS);
    localparam int SCALE_W    = 16 + SEG_W;
    localparam int PAL_IDX_W  = $clog2(PAL_N);
    localparam int CFG_ADDR_W = 3;
    localparam int CFG_DATA_W = 32;

    typedef enum logic [CFG_ADDR_W-1:0] {
        CFG_GAIN   = 3'd0,
        CFG_OFFSET = 3'd1,
        CFG_COLOR0 = 3'd2,
        CFG_COLOR1 = 3'd3,
        CFG_COLOR2 = 3'd4,
        CFG_COLOR3 = 3'd5,
        CFG_COLOR4 = 3'd6
    } t_cfg_reg;

    typedef struct packed {
        logic [7:0] red;
        logic [7:0] green;
        logic [7:0] blue;
    } t_color;

    localparam logic [31:0] GAIN_RESET   = 32'h0001_0000;
    localparam logic [31:0] OFFSET_RESET = 32'h0000_0000;

    localparam t_color PAL_RESET [PAL_N] = '{
        24'h000000, 24'h404040, 24'h808080, 24'hC0C0C0, 24'hFFFFFF
    };

endpackage

// ===== hw/rtl/hcr_mix.sv =====
// per channel linear blend of two palette colors, rounded to nearest
// depends on hcr_pkg
module hcr_mix (
    input  hcr_pkg::t_color i_c0,
    input  hcr_pkg::t_color i_c1,
    input  logic [15:0]     i_w,
    output hcr_pkg::t_color o_color
);
    import hcr_pkg::*;

    function automatic logic [7:0] blend(input logic [7:0] a, input logic [7:0] b,
                                         input logic [15:0] w);
        logic [16:0] wa;
        logic [24:0] acc;
        wa  = 17'h10000 - {1'b0, w};
        acc = 25'(a) * 25'(wa) + 25'(b) * 25'(w) + 25'h8000;
        return acc[23:16];
    endfunction

    assign o_color.red   = blend(i_c0.red,   i_c1.red,   i_w);
    assign o_color.green = blend(i_c0.green, i_c1.green, i_w);
    assign o_color.blue  = blend(i_c0.blue,  i_c1.blue,  i_w);

endmodule

// ===== hw/rtl/height_to_color_ramp.sv =====
// height to color ramp: four register stages (multiply, offset and clamp,
// segment select, blend); throughput one beat per cycle unless the output stalls;
// a stalled output holds every full stage, empty ones still fill
// reset is synchronous active low: clears stage valids, loads register defaults
// depends on hcr_pkg and hcr_mix
module height_to_color_ramp (
    input  logic                             i_clk,
    input  logic                             i_rst_n,
    input  logic                             i_cfg_we,
    input  logic [hcr_pkg::CFG_ADDR_W-1:0]   i_cfg_addr,
    input  logic [hcr_pkg::CFG_DATA_W-1:0]   i_cfg_data,
    input  logic                             s_axis_tvalid,
    output logic                             s_axis_tready,
    input  logic [15:0]                      s_axis_tdata,  // height
    input  logic                             s_axis_tlast,
    output logic                             m_axis_tvalid,
    input  logic                             m_axis_tready,
    output logic [23:0]                      m_axis_tdata,  // blue, green, red from msb down
    output logic                             m_axis_tlast
);
    import hcr_pkg::*;

    logic [31:0] r_gain;
    logic [31:0] r_offset;
    t_color      r_pal [PAL_N];

    logic [3:0]  r_vld;
    logic [3:0]  w_adv;
    logic [3:0]  r_last;

    logic signed [47:0] r1_prod;
    logic [15:0]        r2_pos;
    t_color             r3_c0;
    t_color             r3_c1;
    logic [15:0]        r3_w;
    t_color             r4_color;

    logic signed [48:0] n_prod;
    logic signed [32:0] n_sum;
    logic [15:0]        n_pos;
    logic [SCALE_W-1:0] n_scaled;
    logic [PAL_IDX_W-1:0] n_idx0;
    logic [PAL_IDX_W-1:0] n_idx1;
    t_color             n_color;

    // config registers
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_gain   <= GAIN_RESET;
            r_offset <= OFFSET_RESET;
            for (int i = 0; i < PAL_N; i++) r_pal[i] <= PAL_RESET[i];
        end else if (i_cfg_we) begin
            priority if (i_cfg_addr == CFG_GAIN) begin
                r_gain <= i_cfg_data;
            end else if (i_cfg_addr == CFG_OFFSET) begin
                r_offset <= i_cfg_data;
            end else if (i_cfg_addr >= CFG_COLOR0 &&
                         i_cfg_addr < CFG_ADDR_W'(CFG_COLOR0 + PAL_N)) begin
                r_pal[PAL_IDX_W'(i_cfg_addr - CFG_COLOR0)] <= i_cfg_data[23:0];
            end else begin
                r_gain <= r_gain;
            end
        end
    end

    // stage handshake
    assign w_adv[3] = !r_vld[3] || m_axis_tready;
    assign w_adv[2] = !r_vld[2] || w_adv[3];
    assign w_adv[1] = !r_vld[1] || w_adv[2];
    assign w_adv[0] = !r_vld[0] || w_adv[1];
    assign s_axis_tready = w_adv[0];

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_vld <= '0;
        end else begin
            if (w_adv[0]) r_vld[0] <= s_axis_tvalid;
            if (w_adv[1]) r_vld[1] <= r_vld[0];
            if (w_adv[2]) r_vld[2] <= r_vld[1];
            if (w_adv[3]) r_vld[3] <= r_vld[2];
        end
    end

    // stage datapath
    always_comb begin
        n_prod = $signed(s_axis_tdata) * $signed({1'b0, r_gain});
        n_sum  = $signed({r1_prod[47], r1_prod[47:16]}) + $signed({r_offset[31], r_offset});
        if (n_sum[32]) begin
            n_pos = '0;
        end else if (n_sum[31:16] != '0) begin
            n_pos = 16'hFFFF;
        end else begin
            n_pos = n_sum[15:0];
        end
        n_scaled = SCALE_W'(r2_pos) * SCALE_W'(NUM_COLORS - 1);
        n_idx0   = PAL_IDX_W'(n_scaled[SCALE_W-1:16]);
        n_idx1   = n_idx0 + PAL_IDX_W'(1);
    end

    hcr_mix u_mix (
        .i_c0    (r3_c0),
        .i_c1    (r3_c1),
        .i_w     (r3_w),
        .o_color (n_color)
    );

    always_ff @(posedge i_clk) begin
        if (w_adv[0]) begin
            r1_prod   <= n_prod[47:0];
            r_last[0] <= s_axis_tlast;
        end
        if (w_adv[1]) begin
            r2_pos    <= n_pos;
            r_last[1] <= r_last[0];
        end
        if (w_adv[2]) begin
            r3_c0     <= r_pal[n_idx0];
            r3_c1     <= r_pal[n_idx1];
            r3_w      <= n_scaled[15:0];
            r_last[2] <= r_last[1];
        end
        if (w_adv[3]) begin
            r4_color  <= n_color;
            r_last[3] <= r_last[2];
        end
    end

    assign m_axis_tvalid = r_vld[3];
    assign m_axis_tdata  = {r4_color.blue, r4_color.green, r4_color.red};
    assign m_axis_tlast  = r_last[3];

`ifndef SYNTHESIS
    a_accept_enters: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        s_axis_tvalid && s_axis_tready |=> r_vld[0])
        else $error("accepted beat did not enter first stage");

    a_no_bubble_stall: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        !s_axis_tready |-> (r_vld == 4'hF))
        else $error("input stalled while a stage is empty");

    a_seg_range: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_vld[1] |-> (n_idx0 <= PAL_IDX_W'(NUM_COLORS - 2)))
        else $error("palette segment out of range");

    a_out_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        m_axis_tvalid && !m_axis_tready |=> m_axis_tvalid && $stable(m_axis_tdata))
        else $error("stalled output beat changed");
`endif

endmodule

// ===== tb/hcr_ramp_checker.sv =====
// color ramp checker: mirrors the gain, offset and palette registers from the
// config port, predicts one color per accepted height beat and compares results
// depends on hcr_pkg
`timescale 1ns / 100ps

module hcr_ramp_checker (
    input  logic                           i_clk,
    input  logic                           i_rst_n,
    input  logic                           i_cfg_we,
    input  logic [hcr_pkg::CFG_ADDR_W-1:0] i_cfg_addr,
    input  logic [hcr_pkg::CFG_DATA_W-1:0] i_cfg_data,
    input  logic                           i_s_tvalid,
    input  logic                           i_s_tready,
    input  logic [15:0]                    i_s_tdata,   // height
    input  logic                           i_s_tlast,
    input  logic                           i_m_tvalid,
    input  logic                           i_m_tready,
    input  logic [23:0]                    i_m_tdata,   // blue, green, red from msb down
    input  logic                           i_m_tlast,
    output int                             o_fail_count,
    output int                             o_pending
);
    import hcr_pkg::*;

    typedef struct {
        t_color color;
        logic   last;
    } t_ramp_beat;

    logic [31:0] gain_q;
    longint      offset_q;
    t_color      pal_q [PAL_N];
    t_ramp_beat  color_due [$];
    int          faults = 0;

    function automatic logic [7:0] blend(input logic [7:0] a, input logic [7:0] b,
                                         input logic [15:0] w);
        int acc;
        acc = int'(a) * (65536 - int'(w)) + int'(b) * int'(w) + 32768;
        return 8'(acc >> 16);
    endfunction

    function automatic t_color ramp_color(input logic [15:0] height);
        longint h;
        longint g;
        longint pos;
        int     scaled;
        int     seg;
        logic [15:0] w;
        t_color lo;
        t_color hi;
        t_color c;
        h = longint'($signed(height));
        g = gain_q;
        pos = ((h * g) >>> 16) + offset_q;
        if (pos < 0) pos = 0;
        if (pos > 65535) pos = 65535;
        scaled = int'(pos) * (NUM_COLORS - 1);
        seg = scaled >> 16;
        w = scaled[15:0];
        if (seg > PAL_N - 2) seg = PAL_N - 2;
        lo = pal_q[seg];
        hi = pal_q[seg + 1];
        c.red   = blend(lo.red, hi.red, w);
        c.green = blend(lo.green, hi.green, w);
        c.blue  = blend(lo.blue, hi.blue, w);
        return c;
    endfunction

    always @(posedge i_clk) begin
        t_ramp_beat got;
        t_ramp_beat want;
        t_ramp_beat due;
        if (!i_rst_n) begin
            gain_q   = GAIN_RESET;
            offset_q = longint'($signed(OFFSET_RESET));
            for (int i = 0; i < PAL_N; i++) pal_q[i] = PAL_RESET[i];
            color_due.delete();
        end else begin
            if (i_s_tvalid && i_s_tready) begin
                due.color = ramp_color(i_s_tdata);
                due.last  = i_s_tlast;
                color_due = {color_due, due};
            end
            if (i_m_tvalid && i_m_tready) begin
                got.color.red   = i_m_tdata[7:0];
                got.color.green = i_m_tdata[15:8];
                got.color.blue  = i_m_tdata[23:16];
                got.last        = i_m_tlast;
                if (color_due.size() == 0) begin
                    faults++;
                    if (faults <= 10)
                        $display("%0t: unexpected output beat rgb=%h/%h/%h last=%b", $realtime,
                                 got.color.red, got.color.green, got.color.blue, got.last);
                end else begin
                    want = color_due.pop_front();
                    if (got.color.red !== want.color.red || got.color.green !== want.color.green
                        || got.color.blue !== want.color.blue || got.last !== want.last) begin
                        faults++;
                        if (faults <= 10)
                            $display("%0t: mismatch exp rgb=%h/%h/%h last=%b got %h/%h/%h last=%b",
                                     $realtime, want.color.red, want.color.green,
                                     want.color.blue, want.last, got.color.red,
                                     got.color.green, got.color.blue, got.last);
                    end
                end
            end
            if (i_cfg_we) begin
                case (i_cfg_addr)
                    CFG_GAIN:   gain_q = i_cfg_data;
                    CFG_OFFSET: offset_q = longint'($signed(i_cfg_data));
                    CFG_COLOR0, CFG_COLOR1, CFG_COLOR2, CFG_COLOR3, CFG_COLOR4:
                        pal_q[int'(i_cfg_addr) - int'(CFG_COLOR0)] = t_color'(i_cfg_data[23:0]);
                    default: ;
                endcase
            end
        end
        o_pending    <= color_due.size();
        o_fail_count <= faults;
    end

endmodule

// ===== tb/tb.sv =====
// testbench top for height_to_color_ramp: clock, reset, register settings,
// height beats with random gaps and output stalls; verdict from hcr_ramp_checker
// depends on hcr_pkg, height_to_color_ramp and hcr_ramp_checker
`timescale 1ns / 100ps

module tb;
    import hcr_pkg::*;

    localparam logic [CFG_ADDR_W-1:0] CFG_SPARE = 3'd7;
    localparam int HOLD_CYCLES   = 300;
    localparam int PHASES        = 8;
    localparam int PHASE_HEIGHTS = 170;
    localparam int LIMIT_CYCLES  = 1_000_000;

    logic                  i_clk;
    logic                  i_rst_n;
    logic                  i_cfg_we;
    logic [CFG_ADDR_W-1:0] i_cfg_addr;
    logic [CFG_DATA_W-1:0] i_cfg_data;
    logic                  s_axis_tvalid;
    logic                  s_axis_tready;
    logic [15:0]           s_axis_tdata;   // height
    logic                  s_axis_tlast;
    logic                  m_axis_tvalid;
    logic                  m_axis_tready;
    logic [23:0]           m_axis_tdata;   // blue, green, red from msb down
    logic                  m_axis_tlast;

    int fail_count;
    int pending;
    bit no_idle  = 1'b0;
    bit hold_out = 1'b0;

    height_to_color_ramp i_dut (
        .i_clk         (i_clk),
        .i_rst_n       (i_rst_n),
        .i_cfg_we      (i_cfg_we),
        .i_cfg_addr    (i_cfg_addr),
        .i_cfg_data    (i_cfg_data),
        .s_axis_tvalid (s_axis_tvalid),
        .s_axis_tready (s_axis_tready),
        .s_axis_tdata  (s_axis_tdata),
        .s_axis_tlast  (s_axis_tlast),
        .m_axis_tvalid (m_axis_tvalid),
        .m_axis_tready (m_axis_tready),
        .m_axis_tdata  (m_axis_tdata),
        .m_axis_tlast  (m_axis_tlast)
    );

    hcr_ramp_checker i_checker (
        .i_clk        (i_clk),
        .i_rst_n      (i_rst_n),
        .i_cfg_we     (i_cfg_we),
        .i_cfg_addr   (i_cfg_addr),
        .i_cfg_data   (i_cfg_data),
        .i_s_tvalid   (s_axis_tvalid),
        .i_s_tready   (s_axis_tready),
        .i_s_tdata    (s_axis_tdata),
        .i_s_tlast    (s_axis_tlast),
        .i_m_tvalid   (m_axis_tvalid),
        .i_m_tready   (m_axis_tready),
        .i_m_tdata    (m_axis_tdata),
        .i_m_tlast    (m_axis_tlast),
        .o_fail_count (fail_count),
        .o_pending    (pending)
    );

    initial begin
        i_clk = 1'b0;
        forever #6 i_clk = ~i_clk;
    end

    initial begin
        #(12.0 * LIMIT_CYCLES);
        $display("Verification failed");
        $finish;
    end

    // mostly short, a few long
    function automatic int idle_len();
        int r;
        r = $urandom_range(0, 99);
        if (r < 75) return $urandom_range(1, 3);
        if (r < 95) return $urandom_range(4, 12);
        return $urandom_range(20, 60);
    endfunction

    function automatic logic [15:0] rand_height();
        logic [15:0] h;
        h = 16'($urandom);
        if ($urandom_range(0, 1) == 1)
            h = 16'($signed(h) >>> $urandom_range(1, 12));
        return h;
    endfunction

    // output side stalls
    initial begin
        m_axis_tready = 1'b0;
        @(posedge i_clk);
        while (!i_rst_n) @(posedge i_clk);
        forever begin
            if (hold_out) begin
                m_axis_tready <= 1'b0;
                repeat (HOLD_CYCLES) @(posedge i_clk);
                hold_out = 1'b0;
            end else if (no_idle || $urandom_range(0, 2) != 0) begin
                m_axis_tready <= 1'b1;
                repeat ($urandom_range(1, 10)) @(posedge i_clk);
            end else begin
                m_axis_tready <= 1'b0;
                repeat (idle_len()) @(posedge i_clk);
            end
        end
    end

    task automatic send_height(input logic [15:0] height, input logic last_flag);
        int gap;
        s_axis_tvalid <= 1'b1;
        s_axis_tdata  <= height;
        s_axis_tlast  <= last_flag;
        @(posedge i_clk);
        while (!s_axis_tready) @(posedge i_clk);
        gap = (no_idle || $urandom_range(0, 1) == 0) ? 0 : idle_len();
        if (gap > 0) begin
            s_axis_tvalid <= 1'b0;
            s_axis_tdata  <= 16'($urandom);
            repeat (gap) @(posedge i_clk);
        end
    endtask

    // let the clock advance before polling so the count already holds the last accepted beat
    task automatic drain();
        s_axis_tvalid <= 1'b0;
        @(posedge i_clk);
        while (pending != 0) @(posedge i_clk);
    endtask

    task automatic write_reg(input logic [CFG_ADDR_W-1:0] addr, input logic [31:0] data);
        i_cfg_we   <= 1'b1;
        i_cfg_addr <= addr;
        i_cfg_data <= data;
        @(posedge i_clk);
    endtask

    // pal_mode 0: reset palette, 1: random, 2: alternating black and white
    task automatic load_settings(input logic [31:0] gain, input logic [31:0] offset,
                                 input int pal_mode);
        t_color c;
        write_reg(CFG_GAIN, gain);
        write_reg(CFG_OFFSET, offset);
        for (int i = 0; i < PAL_N; i++) begin
            case (pal_mode)
                0:       c = PAL_RESET[i];
                1:       c = t_color'(24'($urandom));
                default: c = (i % 2 == 0) ? t_color'(24'h000000) : t_color'(24'hFFFFFF);
            endcase
            write_reg(CFG_ADDR_W'(CFG_COLOR0) + CFG_ADDR_W'(i), {8'($urandom), c});
        end
        write_reg(CFG_SPARE, $urandom);
        i_cfg_we <= 1'b0;
    endtask

    initial begin
        logic [15:0] walk_a [10] = '{16'h8000, 16'hFFFF, 16'h0000, 16'h0001, 16'h0064,
                                     16'h3FFF, 16'h4000, 16'h4001, 16'h7FFF, 16'h5555};
        logic [15:0] walk_b [7]  = '{16'h8000, 16'hBFFF, 16'hC000, 16'h0000,
                                     16'h3FFF, 16'h4000, 16'h7FFF};
        logic [31:0] gain;
        logic [31:0] offset;
        int          pal_mode;

        i_rst_n       = 1'b0;
        i_cfg_we      = 1'b0;
        i_cfg_addr    = '0;
        i_cfg_data    = '0;
        s_axis_tvalid = 1'b0;
        s_axis_tdata  = '0;
        s_axis_tlast  = 1'b0;
        repeat (12) @(posedge i_clk);
        i_rst_n <= 1'b1;

        // reset settings: unit gain, zero offset
        foreach (walk_a[i]) send_height(walk_a[i], logic'(i % 2));
        drain();

        // gain 2.0, offset 0.5: both clamps reachable
        load_settings(32'h0002_0000, 32'h0000_8000, 0);
        foreach (walk_b[i]) send_height(walk_b[i], logic'(i == 6));
        drain();

        for (int ph = 0; ph < PHASES; ph++) begin
            pal_mode = 1;
            case (ph)
                0: gain = 32'h0;
                1: begin gain = 32'hFFFF_FFFF; offset = 32'h8000_0000; pal_mode = 2; end
                2: begin gain = 32'hFFFF_FFFF; offset = 32'h7FFF_FFFF; end
                3: gain = 32'h1;
                default: gain = $urandom_range(32'h4000, 32'h8_0000);
            endcase
            if (ph == 0 || ph >= 3)
                offset = 32'($urandom_range(0, 32'h2_0000)) - 32'h8000;
            if (ph == 4) pal_mode = 2;
            load_settings(gain, offset, pal_mode);
            no_idle = (ph == 6);
            for (int n = 0; n < PHASE_HEIGHTS; n++) begin
                if (ph == 5 && n == 40) hold_out = 1'b1;
                send_height(rand_height(), $urandom_range(0, 15) == 0);
            end
            drain();
            no_idle = 1'b0;
        end

        repeat (20) @(posedge i_clk);
        if (fail_count == 0 && pending == 0) begin
            $display("Verification passed");
        end else begin
            $display("Verification failed");
        end
        $finish;
    end

endmodule
